FILE: rtl/sae_pkg.sv
`default_nettype none

package sae_pkg;

  // table geometry
  localparam int ENTRY_COUNT = 64;
  localparam int SLOTS       = 8;

  localparam int IDX_W  = 6;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [7:0] Y_LIMIT      = 8'd239;
  localparam logic [7:0] SHORT_HEIGHT = 8'd8;
  localparam logic [7:0] TALL_HEIGHT  = 8'd16;

  // input item kinds
  localparam logic [1:0] MODE_SET_ADDR = 2'd0;
  localparam logic [1:0] MODE_WRITE    = 2'd1;
  localparam logic [1:0] MODE_READ     = 2'd2;
  localparam logic [1:0] MODE_EVAL     = 2'd3;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  we;
    byte_t addr;
    byte_t data;
  } mem_wr_t;

endpackage

`default_nettype wire

FILE: rtl/sae_mem.sv
`default_nettype none

module sae_mem (
  input  wire logic            clk,
  input  wire sae_pkg::mem_wr_t wr,
  input  wire sae_pkg::byte_t   raddr,
  output sae_pkg::byte_t        rdata
);
  import sae_pkg::*;

  byte_t mem [256];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sprite_attribute_memory_evaluator.sv
// transfers: set address and write complete at their transfer; a read result passes through
//   ST_READ, which waits for a free output register before loading it
// evaluate: every entry is scanned through the shared range compare, then each selected entry
//   is fetched (ST_FETCH) and output (ST_PUSH); an empty scanline gives a single output
// input: address and write items one per cycle; reads and evaluates hold s_tready low until done
// reset: synchronous; a clearing pass then zeroes all 256 memory bytes, s_tready low
`default_nettype none

module sprite_attribute_memory_evaluator (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: tall_sprites
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // mode[1:0], data_byte[9:2], scanline[17:10], zero pad
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,  // read_data, sprite_y, tile, sprite_attr, sprite_x,
                                     // sprite_number[45:40], selected_count[49:46],
                                     // overflow[50], zero pad
  output logic             m_tuser,  // sprite_valid
  output logic             m_tlast   // last
);
  import sae_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FETCH = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  logic [2:0]  state;
  logic        tall_sprites;
  byte_t       access_address;
  byte_t       clr_addr;

  // scan state
  byte_t              eval_line;
  logic [IDX_W-1:0]   idx;
  logic               issue_done;
  logic               chk_valid;
  logic [IDX_W-1:0]   chk_idx;
  logic [CNT_W-1:0]   nsel;
  logic [CNT_W-1:0]   nsel_next;
  logic [IDX_W-1:0]   chosen [SLOTS];

  // fetch state
  logic [SLOT_W-1:0]  k;
  logic [2:0]         fb;
  byte_t              fbytes [4];

  // memory port
  mem_wr_t            wr;
  byte_t              raddr;
  byte_t              rdata;

  // input fields
  logic [1:0] in_mode;
  byte_t      in_data;
  byte_t      in_line;

  assign in_mode = s_tdata[1:0];
  assign in_data = s_tdata[9:2];
  assign in_line = s_tdata[17:10];

  logic accept;
  logic out_free;
  logic push;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  // a result is loaded into the output register this cycle
  assign push     = ((state == ST_READ) || (state == ST_PUSH)) && out_free;

  // shared range compare: scanline - (y + 1) must lie in [0, height)
  byte_t      height;
  logic [8:0] diff;
  logic       hit;

  always_comb begin
    height = tall_sprites ? TALL_HEIGHT : SHORT_HEIGHT;
    diff   = {1'b0, eval_line} - {1'b0, rdata} - 9'd1;
    hit    = chk_valid && (rdata <= Y_LIMIT) && !diff[8] && (diff[7:0] < height);
    nsel_next = nsel;
    if (hit && (nsel < CNT_W'(SLOTS))) begin
      nsel_next = nsel + CNT_W'(1);
    end
  end

  // evaluate result word: count and overflow always, entry bytes when one is selected
  logic [55:0] push_data;

  always_comb begin
    push_data        = '0;
    push_data[49:46] = 4'(nsel);
    push_data[50]    = (nsel == CNT_W'(SLOTS));
    if (nsel != '0) begin
      push_data[15:8]  = fbytes[0];
      push_data[23:16] = fbytes[1];
      push_data[31:24] = fbytes[2];
      push_data[39:32] = fbytes[3];
      push_data[45:40] = chosen[k];
    end
  end

  // memory write port: the clearing pass, else write items
  always_comb begin
    wr.we   = 1'b0;
    wr.addr = access_address;
    wr.data = in_data;
    if (state == ST_CLEAR) begin
      wr.we   = 1'b1;
      wr.addr = clr_addr;
      wr.data = '0;
    end else if (accept && (in_mode == MODE_WRITE)) begin
      wr.we = 1'b1;
    end
  end

  // memory read address follows the sequencer
  always_comb begin
    case (state)
      ST_SCAN:  raddr = {idx, 2'b00};
      ST_FETCH: raddr = {chosen[k], fb[1:0]};
      default:  raddr = access_address;
    endcase
  end

  sae_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tall_sprites <= 1'b0;
    end else if (cfg_we) begin
      tall_sprites <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      access_address <= '0;
      m_tvalid       <= 1'b0;
      chk_valid      <= 1'b0;
      issue_done     <= 1'b0;
      nsel           <= '0;
      idx            <= '0;
      k              <= '0;
      fb             <= '0;
    end else begin
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 8'd1;
          if (clr_addr == 8'hff) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (in_mode)
              MODE_SET_ADDR: access_address <= in_data;
              MODE_WRITE:    access_address <= access_address + 8'd1;
              MODE_READ:     state <= ST_READ;
              MODE_EVAL: begin
                eval_line  <= in_line;
                idx        <= '0;
                issue_done <= 1'b0;
                chk_valid  <= 1'b0;
                nsel       <= '0;
                state      <= ST_SCAN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_READ: begin
          // read data registered from the access address in the previous cycle
          if (out_free) begin
            m_tdata  <= {48'd0, rdata};
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          // issue one y address a cycle, test it the cycle after
          chk_valid <= !issue_done;
          chk_idx   <= idx;
          if (!issue_done) begin
            if (idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
          if (hit && (nsel < CNT_W'(SLOTS))) begin
            chosen[nsel[SLOT_W-1:0]] <= chk_idx;
          end
          nsel <= nsel_next;
          if (chk_valid && (chk_idx == LAST_IDX)) begin
            k     <= '0;
            fb    <= '0;
            state <= (nsel_next != '0) ? ST_FETCH : ST_PUSH;
          end
        end
        ST_FETCH: begin
          // bytes y, tile, attribute, x arrive in the cycle after their address
          if (fb != 3'd0) begin
            fbytes[2'(fb - 3'd1)] <= rdata;
          end
          if (fb == 3'd4) begin
            state <= ST_PUSH;
          end else begin
            fb <= fb + 3'd1;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            m_tdata <= push_data;
            if (nsel == '0) begin
              // empty scanline: a single result with no entry
              m_tuser <= 1'b0;
              m_tlast <= 1'b1;
              state   <= ST_IDLE;
            end else begin
              m_tuser <= 1'b1;
              if ((CNT_W'(k) + CNT_W'(1)) == nsel) begin
                m_tlast <= 1'b1;
                state   <= ST_IDLE;
              end else begin
                m_tlast <= 1'b0;
                k       <= k + SLOT_W'(1);
                fb      <= '0;
                state   <= ST_FETCH;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sae_checker.sv
`default_nettype none

module sae_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // no input right after reset, as the clearing pass begins
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

  // read results and empty scanlines carry no entry and close the item
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[55:8] == 48'd0))
    else $error("entry fields set without a selected entry");

  // a selected entry has a visible y, a nonzero count and no read data
  a_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[15:8] <= 8'd239) && (m_tdata[49:46] != 4'd0)
                           && (m_tdata[7:0] == 8'd0))
    else $error("selected entry inconsistent");

endmodule

bind sprite_attribute_memory_evaluator sae_checker u_sae_checker (.*);

`default_nettype wire
